// ----- design/qrm_pkg.sv -----
// Shared types and constants for the quaternion to rotation matrix block.
// Depends on nothing; every other file in the design imports it.
package qrm_pkg;

    // Component width is fixed by the Q1.14 interface format.
    localparam int QRM_DATA_WIDTH = 16;
    localparam int QRM_FRAC_BITS  = 14;

    // Matrix elements, one divider lane each.
    localparam int QRM_LANES = 9;

    // Exact product, pair sum, numerator and magnitude widths.
    localparam int QRM_PROD_WIDTH = 2 * QRM_DATA_WIDTH;
    localparam int QRM_PAIR_WIDTH = QRM_PROD_WIDTH + 1;
    localparam int QRM_NUM_WIDTH  = QRM_PROD_WIDTH + 2;
    localparam int QRM_MAG_WIDTH  = QRM_PROD_WIDTH + 1;

    typedef logic signed [QRM_DATA_WIDTH-1:0] qrm_data_t;
    typedef logic [QRM_MAG_WIDTH-1:0]         mag_t;

    typedef struct packed {
        qrm_data_t qx;
        qrm_data_t qy;
        qrm_data_t qz;
        qrm_data_t qw;
    } quat_t;

    typedef struct packed {
        qrm_data_t r00;
        qrm_data_t r01;
        qrm_data_t r02;
        qrm_data_t r10;
        qrm_data_t r11;
        qrm_data_t r12;
        qrm_data_t r20;
        qrm_data_t r21;
        qrm_data_t r22;
        logic      zero_length;
    } matrix_t;

    // One division job: squared length and nine sign/magnitude numerators.
    typedef struct packed {
        logic                          valid;
        logic                          zero_len;
        mag_t                          len;
        logic [QRM_LANES-1:0]          neg;
        logic [QRM_LANES-1:0][QRM_MAG_WIDTH-1:0] num;
    } div_job_t;

endpackage

// ----- design/quaternion_to_rotation_matrix.sv -----
// Top level: quaternion (Q1.14) to normalized 3x3 rotation matrix (Q1.14).
// Depends on qrm_pkg and qrm_divider.
//
// One quaternion beat is taken on every cycle that start is high; busy is
// always low. The matrix comes out as a single-cycle beat marked by done,
// in input order. The receiver cannot stall, so every beat must be taken
// the cycle it shows. The divider takes most of the pipeline: FRAC_BITS + 2
// stages across nine lanes, one quotient bit in each but the last, which
// rounds, behind four stages of exact products, pair sums, numerators and
// sign/magnitude conversion. Each element is the exact numerator *
// 2^FRAC_BITS / (x^2+y^2+z^2+w^2), rounded to nearest with ties away from
// zero and saturated. An all-zero quaternion raises zero_length and returns
// an all-zero matrix.
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  qrm_pkg::quat_t   quat,
    output logic             done,
    output qrm_pkg::matrix_t matrix
);
    import qrm_pkg::*;

    localparam int PW = QRM_PROD_WIDTH;
    localparam int SW = QRM_PAIR_WIDTH;
    localparam int NW = QRM_NUM_WIDTH;
    localparam int MW = QRM_MAG_WIDTH;

    // Pipeline never holds off: every start is a beat.
    assign busy = 1'b0;

    // ---- stage 1: ten exact products ----
    logic                 s1_valid_reg;
    logic signed [PW-1:0] sq_x_reg, sq_y_reg, sq_z_reg, sq_w_reg;
    logic signed [PW-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;

    always_ff @(posedge clk)
    begin
        sq_x_reg <= PW'(quat.qx) * PW'(quat.qx);
        sq_y_reg <= PW'(quat.qy) * PW'(quat.qy);
        sq_z_reg <= PW'(quat.qz) * PW'(quat.qz);
        sq_w_reg <= PW'(quat.qw) * PW'(quat.qw);
        xy_reg   <= PW'(quat.qx) * PW'(quat.qy);
        zw_reg   <= PW'(quat.qz) * PW'(quat.qw);
        xz_reg   <= PW'(quat.qx) * PW'(quat.qz);
        yw_reg   <= PW'(quat.qy) * PW'(quat.qw);
        yz_reg   <= PW'(quat.qy) * PW'(quat.qz);
        xw_reg   <= PW'(quat.qx) * PW'(quat.qw);
    end

    // ---- stage 2: pair sums ----
    logic                 s2_valid_reg;
    logic signed [SW-1:0] xw2_reg, yz2_reg, xz2_reg, yw2_reg, zw2_reg, xy2_reg;
    logic signed [SW-1:0] d01_reg, d02_reg, d10_reg, d12_reg, d20_reg, d21_reg;

    always_ff @(posedge clk)
    begin
        // diagonal terms: squares grouped as the matrix needs them
        xw2_reg <= SW'(sq_x_reg) + SW'(sq_w_reg);
        yz2_reg <= SW'(sq_y_reg) + SW'(sq_z_reg);
        xz2_reg <= SW'(sq_x_reg) + SW'(sq_z_reg);
        yw2_reg <= SW'(sq_y_reg) + SW'(sq_w_reg);
        zw2_reg <= SW'(sq_z_reg) + SW'(sq_w_reg);
        xy2_reg <= SW'(sq_x_reg) + SW'(sq_y_reg);
        // off-diagonal terms before doubling
        d01_reg <= SW'(xy_reg) - SW'(zw_reg);
        d02_reg <= SW'(xz_reg) + SW'(yw_reg);
        d10_reg <= SW'(xy_reg) + SW'(zw_reg);
        d12_reg <= SW'(yz_reg) - SW'(xw_reg);
        d20_reg <= SW'(xz_reg) - SW'(yw_reg);
        d21_reg <= SW'(yz_reg) + SW'(xw_reg);
    end

    // ---- stage 3: signed numerators and squared length ----
    logic                           s3_valid_reg;
    logic [QRM_LANES-1:0][NW-1:0]   numer_reg;
    mag_t                           len_reg;

    always_ff @(posedge clk)
    begin
        numer_reg[0] <= NW'(xw2_reg) - NW'(yz2_reg);
        numer_reg[1] <= NW'(d01_reg) <<< 1;
        numer_reg[2] <= NW'(d02_reg) <<< 1;
        numer_reg[3] <= NW'(d10_reg) <<< 1;
        numer_reg[4] <= NW'(yw2_reg) - NW'(xz2_reg);
        numer_reg[5] <= NW'(d12_reg) <<< 1;
        numer_reg[6] <= NW'(d20_reg) <<< 1;
        numer_reg[7] <= NW'(d21_reg) <<< 1;
        numer_reg[8] <= NW'(zw2_reg) - NW'(xy2_reg);
        // both halves are non-negative, the sum fits MW bits unsigned
        len_reg      <= MW'($unsigned(xy2_reg)) + MW'($unsigned(zw2_reg));
    end

    // ---- stage 4: sign/magnitude job for the divider ----
    div_job_t job_next;
    div_job_t job_reg;

    always_comb
    begin
        job_next.valid    = s3_valid_reg;
        job_next.zero_len = (len_reg == '0);
        job_next.len      = len_reg;
        for (int l = 0; l < QRM_LANES; l++)
        begin
            job_next.neg[l] = numer_reg[l][NW-1];
            job_next.num[l] = numer_reg[l][NW-1] ? MW'(-numer_reg[l])
                                                 : MW'(numer_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            job_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            job_reg      <= job_next;
        end
    end

    // ---- stages 5 onward: division, rounding, saturation ----
    qrm_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_reg),
        .done   (done),
        .matrix (matrix)
    );

endmodule

// ----- design/qrm_divider.sv -----
// Nine-lane pipelined restoring divider with round-half-away and saturation.
// Depends on qrm_pkg (div_job_t, matrix_t, widths).
module qrm_divider #(
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qrm_pkg::div_job_t job,
    output logic             done,
    output qrm_pkg::matrix_t matrix
);
    import qrm_pkg::*;

    localparam int DW = QRM_DATA_WIDTH;
    localparam int MW = QRM_MAG_WIDTH;
    localparam int QW = FRAC_BITS + 1;
    // rounded quotient is at most 2^FRAC_BITS; CW holds it and the limits
    localparam int CW = ((FRAC_BITS + 2) > DW ? (FRAC_BITS + 2) : DW) + 1;
    localparam logic [CW-1:0] POS_LIM = CW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [CW-1:0] NEG_LIM = CW'(64'd1 << (DW - 1));

    typedef struct packed {
        logic                          zero_len;
        mag_t                          len;
        logic [QRM_LANES-1:0]          neg;
        logic [QRM_LANES-1:0][MW-1:0]  rem;
        logic [QRM_LANES-1:0][QW-1:0]  quo;
    } div_stage_t;

    // stage 0 takes the integer bit, stages 1..FRAC_BITS one fraction bit each
    logic [FRAC_BITS:0] valid_reg;
    div_stage_t         stage_reg  [0:FRAC_BITS];
    div_stage_t         stage_next [0:FRAC_BITS];

    always_comb
    begin
        stage_next[0].zero_len = job.zero_len;
        stage_next[0].len      = job.len;
        stage_next[0].neg      = job.neg;
        for (int l = 0; l < QRM_LANES; l++)
        begin
            if (job.num[l] >= job.len)
            begin
                stage_next[0].rem[l] = job.num[l] - job.len;
                stage_next[0].quo[l] = QW'(1);
            end
            else
            begin
                stage_next[0].rem[l] = job.num[l];
                stage_next[0].quo[l] = '0;
            end
        end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++)
    begin : g_step
        always_comb
        begin
            stage_next[j] = stage_reg[j-1];
            for (int l = 0; l < QRM_LANES; l++)
            begin
                if ({stage_reg[j-1].rem[l], 1'b0} >= {1'b0, stage_reg[j-1].len})
                begin
                    stage_next[j].rem[l] = MW'({stage_reg[j-1].rem[l], 1'b0}
                                               - {1'b0, stage_reg[j-1].len});
                    stage_next[j].quo[l] = {stage_reg[j-1].quo[l][QW-2:0], 1'b1};
                end
                else
                begin
                    stage_next[j].rem[l] = MW'({stage_reg[j-1].rem[l], 1'b0});
                    stage_next[j].quo[l] = {stage_reg[j-1].quo[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRAC_BITS-1:0], job.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= FRAC_BITS; j++)
        begin
            stage_reg[j] <= stage_next[j];
        end
    end

    // rounding, sign and saturation
    logic [QRM_LANES-1:0][DW-1:0] elem_next;
    logic [QRM_LANES-1:0][CW-1:0] rounded;
    matrix_t                      matrix_next;
    matrix_t                      matrix_reg;
    logic                         done_reg;

    always_comb
    begin
        for (int l = 0; l < QRM_LANES; l++)
        begin
            rounded[l] = CW'(stage_reg[FRAC_BITS].quo[l])
                + CW'({stage_reg[FRAC_BITS].rem[l], 1'b0}
                      >= {1'b0, stage_reg[FRAC_BITS].len});
            if (stage_reg[FRAC_BITS].zero_len)
            begin
                elem_next[l] = '0;
            end
            else if (stage_reg[FRAC_BITS].neg[l])
            begin
                if (rounded[l] > NEG_LIM)
                    elem_next[l] = {1'b1, {(DW-1){1'b0}}};
                else
                    elem_next[l] = DW'(~rounded[l] + CW'(1));
            end
            else
            begin
                if (rounded[l] > POS_LIM)
                    elem_next[l] = {1'b0, {(DW-1){1'b1}}};
                else
                    elem_next[l] = DW'(rounded[l]);
            end
        end
        matrix_next.r00         = elem_next[0];
        matrix_next.r01         = elem_next[1];
        matrix_next.r02         = elem_next[2];
        matrix_next.r10         = elem_next[3];
        matrix_next.r11         = elem_next[4];
        matrix_next.r12         = elem_next[5];
        matrix_next.r20         = elem_next[6];
        matrix_next.r21         = elem_next[7];
        matrix_next.r22         = elem_next[8];
        matrix_next.zero_length = stage_reg[FRAC_BITS].zero_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        matrix_reg <= matrix_next;
    end

    assign done   = done_reg;
    assign matrix = matrix_reg;

endmodule

// ----- sim/quaternion_to_rotation_matrix_tb.sv -----
// Self-checking testbench for quaternion_to_rotation_matrix: directed, random and streaming beats.
// Depends on qrm_pkg and the design files; predicts each matrix with exact integer arithmetic.
module quaternion_to_rotation_matrix_tb;
    import qrm_pkg::*;

    // Pipeline depth of the design, in clock cycles.
    localparam int LATENCY        = QRM_FRAC_BITS + 6;
    // Slowest legal gap between two accepted beats is a pipeline drain plus an
    // idle burst; the limit is many times that.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    quat_t   quat;
    logic    done;
    matrix_t matrix;

    // Matrices predicted for accepted quaternions, oldest first.
    matrix_t expected_matrices[$];
    int      mismatch_count;
    int      idle_cycles;

    quaternion_to_rotation_matrix #(
        .FRAC_BITS(QRM_FRAC_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .quat  (quat),
        .done  (done),
        .matrix(matrix)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One element: round(num * 2^FRAC / s), ties away from zero, saturated.
    // |num| <= s always holds, so the shifted magnitude fits in 64 bits.
    function automatic qrm_data_t scale_element(input longint num, input longint s);
        longint mag;
        longint q;
        longint v;
        longint maxv;
        longint minv;
        mag  = (num < 0) ? -num : num;
        // floor(mag*2^F/s + 1/2) without losing the remainder
        q    = ((mag <<< (QRM_FRAC_BITS + 1)) + s) / (2 * s);
        v    = (num < 0) ? -q : q;
        maxv = (longint'(1) <<< (QRM_DATA_WIDTH - 1)) - 1;
        minv = -maxv - 1;
        if (v > maxv)
            v = maxv;
        if (v < minv)
            v = minv;
        return qrm_data_t'(v);
    endfunction

    function automatic matrix_t predict_matrix(input quat_t q);
        longint  x;
        longint  y;
        longint  z;
        longint  w;
        longint  len_sq;
        matrix_t m;
        x      = longint'($signed(q.qx));
        y      = longint'($signed(q.qy));
        z      = longint'($signed(q.qz));
        w      = longint'($signed(q.qw));
        len_sq = x*x + y*y + z*z + w*w;
        m      = '0;
        // All-zero quaternion: flag raised, matrix all zero.
        if (len_sq == 0)
        begin
            m.zero_length = 1'b1;
            return m;
        end
        m.r00 = scale_element(x*x - y*y - z*z + w*w, len_sq);
        m.r01 = scale_element(2 * (x*y - z*w), len_sq);
        m.r02 = scale_element(2 * (x*z + y*w), len_sq);
        m.r10 = scale_element(2 * (x*y + z*w), len_sq);
        m.r11 = scale_element(-x*x + y*y - z*z + w*w, len_sq);
        m.r12 = scale_element(2 * (y*z - x*w), len_sq);
        m.r20 = scale_element(2 * (x*z - y*w), len_sq);
        m.r21 = scale_element(2 * (y*z + x*w), len_sq);
        m.r22 = scale_element(-x*x - y*y + z*z + w*w, len_sq);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: done marks each result for one cycle and is sampled at the edge
    // that closes its cycle. Outputs are flop driven, so the value read
    // here is the one held before the edge.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin : result_check
        matrix_t want;
        if (rst_n && done)
        begin
            if (expected_matrices.size() == 0)
            begin
                report_mismatch("unexpected done beat, queue depth", 0, 1);
            end
            else
            begin
                want = expected_matrices.pop_front();
                if (matrix.r00 !== want.r00)
                    report_mismatch("r00", $signed(want.r00), $signed(matrix.r00));
                if (matrix.r01 !== want.r01)
                    report_mismatch("r01", $signed(want.r01), $signed(matrix.r01));
                if (matrix.r02 !== want.r02)
                    report_mismatch("r02", $signed(want.r02), $signed(matrix.r02));
                if (matrix.r10 !== want.r10)
                    report_mismatch("r10", $signed(want.r10), $signed(matrix.r10));
                if (matrix.r11 !== want.r11)
                    report_mismatch("r11", $signed(want.r11), $signed(matrix.r11));
                if (matrix.r12 !== want.r12)
                    report_mismatch("r12", $signed(want.r12), $signed(matrix.r12));
                if (matrix.r20 !== want.r20)
                    report_mismatch("r20", $signed(want.r20), $signed(matrix.r20));
                if (matrix.r21 !== want.r21)
                    report_mismatch("r21", $signed(want.r21), $signed(matrix.r21));
                if (matrix.r22 !== want.r22)
                    report_mismatch("r22", $signed(want.r22), $signed(matrix.r22));
                if (matrix.zero_length !== want.zero_length)
                    report_mismatch("zero_length", want.zero_length, matrix.zero_length);
            end
        end
    end

    // Watchdog: any accepted beat, in or out, clears the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic quat_t make_quat(input int x, input int y, input int z, input int w);
        quat_t q;
        q.qx = x[15:0];
        q.qy = y[15:0];
        q.qz = z[15:0];
        q.qw = w[15:0];
        return q;
    endfunction

    // One component drawn from a mix of shapes; small and edge values give
    // tiny lengths and heavy cancellation, full range covers every bit.
    function automatic int random_component();
        int mode;
        int mag;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return int'($urandom_range(0, 65535)) - 32768;
        if (mode < 8)
        begin
            mag = $urandom_range(0, 255);
            return ($urandom_range(0, 1) != 0) ? -mag : mag;
        end
        if (mode == 8)
            return 0;
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 1;
            4: return 32767;
            default: return 16384;
        endcase
    endfunction

    // Holds start high until the beat is taken; start is left high so a
    // following beat continues without a dip in the same time step.
    task automatic send_quat(input quat_t q);
        start <= 1'b1;
        quat  <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_matrices.push_back(predict_matrix(q));
    endtask

    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 3) == 0)
            idle_burst($urandom_range(1, 3));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of each component, unit axes, tiny lengths, sign patterns.
    task automatic test_directed();
        send_quat(make_quat(0, 0, 0, 16384));
        send_quat(make_quat(0, 0, 0, -16384));
        send_quat(make_quat(16384, 0, 0, 0));
        send_quat(make_quat(0, 16384, 0, 0));
        send_quat(make_quat(0, 0, 16384, 0));
        send_quat(make_quat(8192, 8192, 8192, 8192));
        send_quat(make_quat(32767, 32767, 32767, 32767));
        send_quat(make_quat(-32768, -32768, -32768, -32768));
        send_quat(make_quat(32767, -32768, 32767, -32768));
        send_quat(make_quat(-32768, 0, 0, 0));
        send_quat(make_quat(0, 0, 0, 32767));
        send_quat(make_quat(1, 0, 0, 0));
        send_quat(make_quat(1, 1, 0, 0));
        send_quat(make_quat(-1, 0, 0, 1));
        send_quat(make_quat(1, -1, 1, -1));
        send_quat(make_quat(100, -200, 300, -400));
        send_quat(make_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA) );
        send_quat(make_quat(-21846, 21845, -21846, 21845));
    endtask

    // Zero length, alone and wedged between normal beats.
    task automatic test_zero_length();
        send_quat(make_quat(0, 0, 0, 0));
        send_quat(make_quat(0, 0, 0, 1));
        send_quat(make_quat(0, 0, 0, 0));
        send_quat(make_quat(0, 0, 0, 0));
        send_quat(make_quat(-32768, 0, 0, 0));
        send_quat(make_quat(0, 0, 0, 0));
    endtask

    // Random quaternions with random idle bursts on the input side.
    task automatic test_random_with_gaps(input int beats);
        repeat (beats)
        begin
            maybe_idle();
            send_quat(make_quat(random_component(), random_component(),
                                random_component(), random_component()));
        end
    endtask

    // Sender holds off until the pipeline has fully drained, then resumes.
    task automatic test_drain_pause(input int rounds);
        repeat (rounds)
        begin
            repeat ($urandom_range(1, 30))
                send_quat(make_quat(random_component(), random_component(),
                                    random_component(), random_component()));
            start <= 1'b0;
            while (expected_matrices.size() != 0)
                @(posedge clk);
        end
    endtask

    // Full rate, one beat every cycle, no idling.
    task automatic test_back_to_back(input int beats);
        repeat (beats)
            send_quat(make_quat(random_component(), random_component(),
                                random_component(), random_component()));
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        quat           <= '0;
        mismatch_count = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_length();
        test_random_with_gaps(1100);
        test_drain_pause(8);
        test_back_to_back(600);

        // Drain: wait for every expected matrix, then wait on to catch any
        // stray done beat.
        start <= 1'b0;
        while (expected_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);

        if (mismatch_count == 0 && expected_matrices.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
